/* hw/rtl/acsc_pkg.sv */
// ----------------------------------------------------------------------------
// acsc_pkg
// Types and constants shared by the active cell set compactor.
// ----------------------------------------------------------------------------
package acsc_pkg;

    localparam int NUM_CELLS = 64;
    localparam int IDX_W     = $clog2(NUM_CELLS);
    localparam int CNT_W     = 7;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] cell_index;
        logic       flag_value;
    } t_cmd;

    typedef struct packed {
        logic       flag_out;
        logic [5:0] active_index;
        logic [6:0] pending_count;
        logic [6:0] current_count;
        logic       is_empty;
        logic       is_last;
    } t_res;

endpackage

/* hw/rtl/active_cell_set_compactor_core.sv */
// ----------------------------------------------------------------------------
// active_cell_set_compactor_core
// Activity bitmap with a running set count and ascending index streaming.
//
// Usage: drive i_cmd and raise i_start; the beat is taken at a clock edge
// where o_busy is low. Results come on o_res, each valid for exactly one
// cycle while o_valid is high; the receiver cannot stall them.
// Write and read: one result in the cycle after the beat; o_busy stays low,
// so a new write or read can follow every cycle.
// Commit: the pending count is latched, then a single cell pointer walks the
// bitmap one cell per cycle and emits each set cell as it is found. The
// walk stops at the last set cell, and o_busy is high throughout. A commit
// on an empty set gives one empty result in the cycle after the beat.
// Unused opcode 3 gives no result.
// Reset (synchronous, active low) clears the bitmap, both counts and the
// sequencer at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module active_cell_set_compactor_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  acsc_pkg::t_cmd i_cmd,
    output logic          o_busy,
    output logic          o_valid,
    output acsc_pkg::t_res o_res
);
    import acsc_pkg::*;

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                 r_state, n_state;
    logic [NUM_CELLS-1:0]   r_bitmap, n_bitmap;
    logic [CNT_W-1:0]       r_set, n_set;
    logic [CNT_W-1:0]       r_latched, n_latched;
    logic [IDX_W-1:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0]       r_seen, n_seen;
    logic                   r_valid, n_valid;
    t_res                   r_res, n_res;

    logic                   in_range;
    logic [IDX_W-1:0]       cidx;
    logic                   old_flag;
    logic                   scan_bit;
    logic                   scan_last;

    assign in_range  = {1'b0, i_cmd.cell_index} < CNT_W'(NUM_CELLS);
    assign cidx      = i_cmd.cell_index[IDX_W-1:0];
    assign old_flag  = in_range & r_bitmap[cidx];
    assign scan_bit  = r_bitmap[r_ptr];
    assign scan_last = (r_seen + CNT_W'(1)) == r_latched;

    always_comb begin
        n_state   = r_state;
        n_bitmap  = r_bitmap;
        n_set     = r_set;
        n_latched = r_latched;
        n_ptr     = r_ptr;
        n_seen    = r_seen;
        n_valid   = 1'b0;
        n_res     = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res.active_index = '0;
                    n_res.is_empty     = 1'b0;
                    n_res.is_last      = 1'b1;
                    n_res.current_count = r_latched;
                    n_res.pending_count = r_set;
                    n_res.flag_out     = old_flag;
                    priority if (i_cmd.opcode == OP_WRITE) begin
                        n_valid = 1'b1;
                        if (in_range && (i_cmd.flag_value != old_flag)) begin
                            n_bitmap[cidx] = i_cmd.flag_value;
                            n_set = i_cmd.flag_value ? r_set + CNT_W'(1)
                                                     : r_set - CNT_W'(1);
                        end
                        n_res.pending_count = n_set;
                        n_res.flag_out      = in_range & i_cmd.flag_value;
                    end else if (i_cmd.opcode == OP_READ) begin
                        n_valid = 1'b1;
                    end else if (i_cmd.opcode == OP_COMMIT) begin
                        n_latched           = r_set;
                        n_res.current_count = r_set;
                        if (r_set == '0) begin
                            n_valid        = 1'b1;
                            n_res.flag_out = 1'b0;
                            n_res.is_empty = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                            n_ptr   = '0;
                            n_seen  = '0;
                        end
                    end else begin
                        n_res = r_res;
                    end
                end
            end
            S_SCAN: begin
                n_ptr = r_ptr + IDX_W'(1);
                if (scan_bit) begin
                    n_valid             = 1'b1;
                    n_seen              = r_seen + CNT_W'(1);
                    n_res.flag_out      = 1'b1;
                    n_res.active_index  = 6'(r_ptr);
                    n_res.pending_count = r_set;
                    n_res.current_count = r_latched;
                    n_res.is_empty      = 1'b0;
                    n_res.is_last       = scan_last;
                    if (scan_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bitmap  <= '0;
            r_set     <= '0;
            r_latched <= '0;
            r_ptr     <= '0;
            r_seen    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bitmap  <= n_bitmap;
            r_set     <= n_set;
            r_latched <= n_latched;
            r_ptr     <= n_ptr;
            r_seen    <= n_seen;
            r_valid   <= n_valid;
        end
        r_res <= n_res;
    end

    assign o_busy  = (r_state == S_SCAN);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hw/rtl/acsc_checker.sv */
// ----------------------------------------------------------------------------
// acsc_checker
// Port-level checks for the active cell set compactor, bound to the core.
// ----------------------------------------------------------------------------
module acsc_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  acsc_pkg::t_cmd i_cmd,
    input  logic           o_busy,
    input  logic           o_valid,
    input  acsc_pkg::t_res o_res
);
    import acsc_pkg::*;

    // write or read beat answers in the next cycle with a single result
    a_rw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_cmd.opcode == OP_WRITE || i_cmd.opcode == OP_READ))
        |=> (o_valid && o_res.is_last && !o_res.is_empty))
        else $error("write/read beat without single result");

    // mid-stream beat keeps the block busy
    a_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.is_last) |-> o_busy)
        else $error("stream beat while not busy");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.is_empty)
        |-> (o_res.is_last && !o_res.flag_out && o_res.current_count == '0))
        else $error("malformed empty result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.pending_count <= CNT_W'(NUM_CELLS)
                     && o_res.current_count <= CNT_W'(NUM_CELLS)))
        else $error("count out of range");

endmodule

bind active_cell_set_compactor_core acsc_checker u_acsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_cmd   (i_cmd),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
